FILE: rtl/core/lcdw_pkg.sv
// lcdw_pkg: request and result types, kind codes, timing constants and
// fixed command tables for the 4-bit lcd write sequencer
// no dependencies
`default_nettype none

package lcdw_pkg;

  localparam int MAX_DIGITS_DEF = 10;

  typedef enum logic [2:0] {
    K_CHAR    = 3'd0,
    K_CURSOR  = 3'd1,
    K_INT     = 3'd2,
    K_CLEAR   = 3'd3,
    K_HOME    = 3'd4,
    K_ENTRY   = 3'd5,
    K_DISP_ON = 3'd6,
    K_INIT    = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic        row;
    logic [6:0]  column;
    logic [30:0] number;
  } in_t;

  typedef struct packed {
    logic [3:0]  nibble;
    logic        rs;
    logic [12:0] delay_after_us;
    logic        last;
  } out_t;

  // job handed from front to back (digits travel beside it)
  typedef struct packed {
    kind_t      kind;
    logic [7:0] code;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_DIV  = 2'd1,
    F_PUSH = 2'd2
  } front_state_t;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_RUN  = 1'b1
  } back_state_t;

  localparam logic [12:0] WAIT_NONE_US  = 13'd0;
  localparam logic [12:0] WAIT_BYTE_US  = 13'd40;
  localparam logic [12:0] WAIT_SHORT_US = 13'd50;
  localparam logic [12:0] WAIT_INIT2_US = 13'd100;
  localparam logic [12:0] WAIT_CLEAR_US = 13'd2000;
  localparam logic [12:0] WAIT_HOME_US  = 13'd2100;
  localparam logic [12:0] WAIT_INIT1_US = 13'd5000;

  localparam logic [2:0]  INIT_LAST_STEP = 3'd5;
  localparam logic [3:0]  ASCII_DIGIT_HI = 4'h3;

  // 2^35 / 10 rounded up: exact quotient for any 32-bit dividend
  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

  // init run, one nibble per step
  function automatic out_t init_step(input logic [2:0] step);
    out_t r;
    r.rs   = 1'b0;
    r.last = 1'b0;
    case (step)
      3'd0: begin r.nibble = 4'h3; r.delay_after_us = WAIT_INIT1_US; end
      3'd1: begin r.nibble = 4'h3; r.delay_after_us = WAIT_INIT2_US; end
      3'd2: begin r.nibble = 4'h3; r.delay_after_us = WAIT_BYTE_US;  end
      3'd3: begin r.nibble = 4'h2; r.delay_after_us = WAIT_SHORT_US; end
      3'd4: begin r.nibble = 4'h2; r.delay_after_us = WAIT_NONE_US;  end
      default: begin
        r.nibble         = 4'hA;
        r.delay_after_us = WAIT_SHORT_US;
        r.last           = 1'b1;
      end
    endcase
    return r;
  endfunction

  // second nibble of the short command pairs
  function automatic out_t cmd_second(input kind_t kind);
    out_t r;
    r.rs   = 1'b0;
    r.last = 1'b1;
    case (kind)
      K_CLEAR: begin r.nibble = 4'h1; r.delay_after_us = WAIT_CLEAR_US; end
      K_HOME:  begin r.nibble = 4'h2; r.delay_after_us = WAIT_HOME_US;  end
      K_ENTRY: begin r.nibble = 4'h4; r.delay_after_us = WAIT_SHORT_US; end
      default: begin r.nibble = 4'hC; r.delay_after_us = WAIT_SHORT_US; end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lcd_4bit_write_sequencer.sv
// lcd_4bit_write_sequencer: top level, front classifier, job queue and
// nibble back end; uses lcdw_pkg, lcdw_front, lcdw_fifo, lcdw_back
//
//   channel  ports                      beat moves
//   input    push, full, in_data        one lcd request (in_t)
//   result   empty, pop, out_data       one nibble write (out_t)
//
// a fixed request reaches the queue in its accept cycle; an integer is
// split into decimal digits in the front, one per step (division by ten
// through a reciprocal multiply), and then pushed as one job.
// the back gives one nibble per cycle: 2, 6 or 2*d per request for d
// digits; it takes each job from the queue only while idle. output
// stalls hold the back, and the front once the two-entry queue is full.
// reset (synchronous, active low) empties the queue and both state machines.
`default_nettype none

module lcd_4bit_write_sequencer
  import lcdw_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire in_t  in_data,
  output logic      full,
  output logic      empty,
  input  wire logic pop,
  output out_t      out_data
);

  localparam int DW    = 4 * MAX_DIGITS;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int QW    = $bits(job_t) + DW + CNT_W;

  job_t             f_job, b_job;
  logic [DW-1:0]    f_digits, b_digits;
  logic [CNT_W-1:0] f_count, b_count;
  logic             q_push, q_full, q_pop, q_empty;

  lcdw_front #(
    .MAX_DIGITS (MAX_DIGITS),
    .DW         (DW),
    .CNT_W      (CNT_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_data    (in_data),
    .full       (full),
    .job_push   (q_push),
    .job        (f_job),
    .job_digits (f_digits),
    .job_count  (f_count),
    .job_full   (q_full)
  );

  lcdw_fifo #(
    .W (QW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({f_job, f_digits, f_count}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata ({b_job, b_digits, b_count}),
    .empty (q_empty)
  );

  lcdw_back #(
    .MAX_DIGITS (MAX_DIGITS),
    .DW         (DW),
    .CNT_W      (CNT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (b_job),
    .job_digits (b_digits),
    .job_count  (b_count),
    .job_empty  (q_empty),
    .job_pop    (q_pop),
    .out_data   (out_data),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

`default_nettype wire

FILE: rtl/core/lcdw_fifo.sv
// lcdw_fifo: two-entry job queue between front and back
// depends on nothing but its width parameter
`default_nettype none

module lcdw_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (PTR_W+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr_r];

  always_comb begin
    wptr_nxt  = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = do_pop  ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= wdata;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PTR_W+1)'(DEPTH))
    else $error("job queue count overflow");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/lcdw_front.sv
// lcdw_front: takes requests, builds the byte code or extracts decimal
// digits one a cycle, and pushes a job; uses lcdw_pkg
`default_nettype none

module lcdw_front
  import lcdw_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int DW         = 4 * MAX_DIGITS,
  parameter int CNT_W      = $clog2(MAX_DIGITS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire in_t              in_data,
  output logic                  full,
  output logic                  job_push,
  output job_t                  job,
  output logic [DW-1:0]         job_digits,
  output logic [CNT_W-1:0]      job_count,
  input  wire logic             job_full
);

  front_state_t     state_r, state_nxt;
  logic [30:0]      num_r, num_nxt;
  logic [DW-1:0]    dig_r, dig_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             accept;
  logic [62:0]      prod;
  logic [27:0]      quot;
  logic [30:0]      quot_x10;
  logic [3:0]       digit;
  logic [6:0]       addr;
  logic             div_done;

  assign full   = (state_r != F_IDLE) || job_full;
  assign accept = push && !full;

  // divide by ten through the reciprocal, remainder by shift-add
  assign prod     = 63'(num_r) * 63'(RECIP_TEN);
  assign quot     = prod[62:35];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign digit    = 4'(num_r - quot_x10);
  assign div_done = (quot == '0) || (cnt_r == CNT_W'(MAX_DIGITS - 1));

  assign addr = {in_data.row, 6'b0} + in_data.column;

  always_comb begin
    state_nxt  = state_r;
    num_nxt    = num_r;
    dig_nxt    = dig_r;
    cnt_nxt    = cnt_r;
    job_push   = 1'b0;
    job.kind   = in_data.kind;
    job.code   = in_data.data_byte;
    job_digits = dig_r;
    job_count  = cnt_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (in_data.kind == K_INT) begin
            num_nxt   = in_data.number;
            cnt_nxt   = '0;
            state_nxt = F_DIV;
          end else begin
            job_push = 1'b1;
            if (in_data.kind == K_CURSOR) begin
              job.code = {1'b1, addr};
            end
          end
        end
      end
      F_DIV: begin
        // new digit enters at the top so the leading digit ends up there
        dig_nxt = (dig_r >> 4) | (DW'(digit) << (DW - 4));
        num_nxt = 31'(quot);
        cnt_nxt = cnt_r + 1'b1;
        if (div_done) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        job.kind = K_INT;
        job_push = 1'b1;
        if (!job_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    dig_r <= dig_nxt;
  end

`ifndef SYNTH
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_DIV) |-> (cnt_r < CNT_W'(MAX_DIGITS)))
    else $error("digit count past limit");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (job_push && state_r == F_IDLE) |-> !job_full)
    else $error("job pushed into full queue");
  a_int_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_PUSH) |-> (cnt_r != '0))
    else $error("integer job with no digits");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/lcdw_back.sv
// lcdw_back: expands queued jobs into nibble writes, one per cycle while
// the output is not stalled, into a registered output stage; uses lcdw_pkg
`default_nettype none

module lcdw_back
  import lcdw_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int DW         = 4 * MAX_DIGITS,
  parameter int CNT_W      = $clog2(MAX_DIGITS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire job_t             job,
  input  wire logic [DW-1:0]    job_digits,
  input  wire logic [CNT_W-1:0] job_count,
  input  wire logic             job_empty,
  output logic                  job_pop,
  output out_t                  out_data,
  output logic                  empty,
  input  wire logic             pop
);

  back_state_t      state_r, state_nxt;
  kind_t            kind_r, kind_nxt;
  logic [7:0]       code_r, code_nxt;
  logic [DW-1:0]    dig_r, dig_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [2:0]       step_r, step_nxt;
  out_t             out_r, out_nxt;
  logic             outv_r, outv_nxt;

  out_t             cur;
  logic             adv;

  assign out_data = out_r;
  assign empty    = !outv_r;
  assign adv      = (state_r == B_RUN) && (!outv_r || pop);

  // nibble for the current step
  always_comb begin
    cur.rs             = 1'b0;
    cur.delay_after_us = WAIT_BYTE_US;
    cur.nibble         = step_r[0] ? code_r[3:0] : code_r[7:4];
    cur.last           = step_r[0];
    case (kind_r)
      K_CHAR: begin
        cur.rs = 1'b1;
      end
      K_CURSOR: begin
        cur.rs = 1'b0;
      end
      K_INT: begin
        cur.rs     = 1'b1;
        cur.nibble = step_r[0] ? dig_r[DW-1 -: 4] : ASCII_DIGIT_HI;
        cur.last   = step_r[0] && (rem_r == CNT_W'(1));
      end
      K_INIT: begin
        cur = init_step(step_r);
      end
      default: begin
        if (step_r[0]) begin
          cur = cmd_second(kind_r);
        end else begin
          cur.nibble         = 4'h0;
          cur.delay_after_us = WAIT_NONE_US;
          cur.last           = 1'b0;
        end
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    code_nxt  = code_r;
    dig_nxt   = dig_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    out_nxt   = out_r;
    outv_nxt  = outv_r && !pop;
    job_pop   = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!job_empty) begin
          job_pop   = 1'b1;
          kind_nxt  = job.kind;
          code_nxt  = job.code;
          dig_nxt   = job_digits;
          rem_nxt   = job_count;
          step_nxt  = '0;
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        if (adv) begin
          out_nxt  = cur;
          outv_nxt = 1'b1;
          step_nxt = step_r + 1'b1;
          if (kind_r == K_INT && step_r[0]) begin
            dig_nxt = dig_r << 4;
            rem_nxt = rem_r - 1'b1;
          end
          if (cur.last) begin
            state_nxt = B_IDLE;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      outv_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      outv_r  <= outv_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    code_r <= code_nxt;
    dig_r  <= dig_nxt;
    rem_r  <= rem_nxt;
    out_r  <= out_nxt;
  end

`ifndef SYNTH
  a_init_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RUN && kind_r == K_INIT) |-> (step_r <= INIT_LAST_STEP))
    else $error("init run past its last nibble");
  a_int_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RUN && kind_r == K_INT) |-> (rem_r != '0))
    else $error("integer run with no digits left");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RUN) |-> !job_pop)
    else $error("job taken while a run is going");
`endif

endmodule

`default_nettype wire

FILE: verif/lcdw_nibble_scoreboard.sv
`timescale 1ns / 100ps
// lcdw_nibble_scoreboard: works out the nibble writes each lcd request should
// produce and checks the beats leaving the sequencer against them
// depends on lcdw_pkg (in_t, out_t, kind codes, MAX_DIGITS_DEF)

import lcdw_pkg::*;

class lcdw_nibble_scoreboard;

  out_t nibbles_due[$];
  int   mismatches;
  int   beats_checked;
  int   requests_seen;
  int   per_kind[8];

  function void queue_nibble(logic [3:0] nib, logic rs, logic [12:0] dly, logic last);
    nibbles_due.push_back('{nibble: nib, rs: rs, delay_after_us: dly, last: last});
  endfunction

  // high nibble first, both with the 40 us byte wait
  function void queue_byte(logic [7:0] code, logic rs, logic last);
    queue_nibble(code[7:4], rs, 13'd40, 1'b0);
    queue_nibble(code[3:0], rs, 13'd40, last);
  endfunction

  function void note_request(in_t req);
    logic [6:0]  addr;
    int unsigned rest;
    logic [3:0]  digs[24];
    int          n;
    requests_seen++;
    per_kind[req.kind]++;
    case (req.kind)
      K_CHAR: queue_byte(req.data_byte, 1'b1, 1'b1);
      K_CURSOR: begin
        // 7-bit sum wraps, which is the address mask
        addr = {req.row, 6'd0} + req.column;
        queue_byte({1'b1, addr}, 1'b0, 1'b1);
      end
      K_INT: begin
        rest = req.number;
        n = 0;
        do begin
          digs[n] = 4'(rest % 10);
          rest = rest / 10;
          n++;
        end while (rest != 0 && n < 24);
        // only the lowest digits survive an overlong number
        if (n > MAX_DIGITS_DEF) n = MAX_DIGITS_DEF;
        for (int i = n - 1; i >= 0; i--) queue_byte({4'h3, digs[i]}, 1'b1, i == 0);
      end
      K_CLEAR: begin
        queue_nibble(4'h0, 1'b0, 13'd0, 1'b0);
        queue_nibble(4'h1, 1'b0, 13'd2000, 1'b1);
      end
      K_HOME: begin
        queue_nibble(4'h0, 1'b0, 13'd0, 1'b0);
        queue_nibble(4'h2, 1'b0, 13'd2100, 1'b1);
      end
      K_ENTRY: begin
        queue_nibble(4'h0, 1'b0, 13'd0, 1'b0);
        queue_nibble(4'h4, 1'b0, 13'd50, 1'b1);
      end
      K_DISP_ON: begin
        queue_nibble(4'h0, 1'b0, 13'd0, 1'b0);
        queue_nibble(4'hC, 1'b0, 13'd50, 1'b1);
      end
      default: begin
        queue_nibble(4'h3, 1'b0, 13'd5000, 1'b0);
        queue_nibble(4'h3, 1'b0, 13'd100, 1'b0);
        queue_nibble(4'h3, 1'b0, 13'd40, 1'b0);
        queue_nibble(4'h2, 1'b0, 13'd50, 1'b0);
        queue_nibble(4'h2, 1'b0, 13'd0, 1'b0);
        queue_nibble(4'hA, 1'b0, 13'd50, 1'b1);
      end
    endcase
  endfunction

  function void compare_field(string name, logic [12:0] want, logic [12:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_beat(out_t got);
    out_t want;
    beats_checked++;
    if (nibbles_due.size() == 0) begin
      $error("nibble beat with nothing expected: %h", got);
      mismatches++;
      return;
    end
    want = nibbles_due.pop_front();
    compare_field("nibble", 13'(want.nibble), 13'(got.nibble));
    compare_field("rs", 13'(want.rs), 13'(got.rs));
    compare_field("delay_after_us", want.delay_after_us, got.delay_after_us);
    compare_field("last", 13'(want.last), 13'(got.last));
  endfunction

endclass

FILE: verif/tb_lcd_4bit_write_sequencer.sv
`timescale 1ns / 100ps
// tb_lcd_4bit_write_sequencer: drives lcd requests into the sequencer and
// pops its nibble beats with random gaps; depends on lcdw_pkg and lcdw_nibble_scoreboard

module tb_lcd_4bit_write_sequencer;
  import lcdw_pkg::*;

  localparam int RANDOM_REQUESTS = 362;
  localparam int CALM_TAIL       = 60;
  localparam int CYCLE_LIMIT     = 200000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic push  = 1'b0;
  in_t  in_data = '0;
  logic pop   = 1'b0;
  logic full;
  logic empty;
  out_t out_data;

  logic calm = 1'b0;
  int   cycles = 0;
  int   pop_stall = 0;

  lcdw_nibble_scoreboard sb;

  lcd_4bit_write_sequencer #(.MAX_DIGITS(MAX_DIGITS_DEF)) dut (
    .clk(clk), .rst_n(rst_n), .push(push), .in_data(in_data), .full(full),
    .empty(empty), .pop(pop), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: values read at the edge are the ones the block saw
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (pop && !empty) sb.check_beat(out_data);
      if (pop_stall > 0) begin
        pop_stall--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        pop_stall = $urandom_range(1, 5) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic in_t make_req(kind_t k, logic [7:0] b, logic r, logic [6:0] c,
                                   logic [30:0] num);
    in_t q;
    q.kind = k;
    q.data_byte = b;
    q.row = r;
    q.column = c;
    q.number = num;
    return q;
  endfunction

  // mostly short numbers, with a share spanning the whole 31-bit range
  function automatic in_t random_req();
    int unsigned top;
    int          digits;
    logic [30:0] num;
    digits = $urandom_range(1, 10);
    top = 1;
    for (int i = 0; i < digits && i < 9; i++) top = top * 10;
    if (digits == 10 || $urandom_range(0, 3) == 0) num = 31'($urandom());
    else num = 31'($urandom_range(0, top - 1));
    return make_req(kind_t'($urandom_range(0, 7)), 8'($urandom()), 1'($urandom()),
                    7'($urandom()), num);
  endfunction

  task automatic send_request(input in_t req);
    push <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (full);
    sb.note_request(req);
  endtask

  task automatic maybe_idle_input();
    if (!calm && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  initial begin
    in_t directed[$];
    sb = new;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(make_req(K_CHAR, 8'h00, 1'b1, 7'h7F, 31'h7FFFFFFF));
    directed.push_back(make_req(K_CHAR, 8'hFF, 1'b0, 7'h00, 31'h0));
    directed.push_back(make_req(K_CHAR, 8'hA5, 1'b1, 7'h2A, 31'h5555));
    directed.push_back(make_req(K_CURSOR, 8'h00, 1'b0, 7'h00, 31'h0));
    directed.push_back(make_req(K_CURSOR, 8'hFF, 1'b1, 7'h00, 31'h7FFFFFFF));
    directed.push_back(make_req(K_CURSOR, 8'h00, 1'b0, 7'h7F, 31'h0));
    directed.push_back(make_req(K_CURSOR, 8'h12, 1'b1, 7'h7F, 31'h0));
    directed.push_back(make_req(K_CURSOR, 8'h00, 1'b1, 7'h3F, 31'h0));
    directed.push_back(make_req(K_INT, 8'hFF, 1'b1, 7'h7F, 31'd0));
    directed.push_back(make_req(K_INT, 8'h00, 1'b0, 7'h00, 31'd9));
    directed.push_back(make_req(K_INT, 8'h00, 1'b0, 7'h00, 31'd10));
    directed.push_back(make_req(K_INT, 8'h00, 1'b0, 7'h00, 31'd999999999));
    directed.push_back(make_req(K_INT, 8'h00, 1'b0, 7'h00, 31'd1000000000));
    directed.push_back(make_req(K_INT, 8'h00, 1'b0, 7'h00, 31'h7FFFFFFF));
    directed.push_back(make_req(K_CLEAR, 8'hFF, 1'b1, 7'h7F, 31'h7FFFFFFF));
    directed.push_back(make_req(K_HOME, 8'h00, 1'b0, 7'h00, 31'h0));
    directed.push_back(make_req(K_ENTRY, 8'h00, 1'b0, 7'h00, 31'h0));
    directed.push_back(make_req(K_DISP_ON, 8'h00, 1'b0, 7'h00, 31'h0));
    directed.push_back(make_req(K_INIT, 8'h00, 1'b0, 7'h00, 31'h0));
    // a second init request, following the first one
    directed.push_back(make_req(K_INIT, 8'hFF, 1'b1, 7'h7F, 31'h7FFFFFFF));
    foreach (directed[i]) begin
      send_request(directed[i]);
      maybe_idle_input();
    end

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i >= RANDOM_REQUESTS - CALM_TAIL) calm = 1'b1;
      send_request(random_req());
      maybe_idle_input();
    end
    push <= 1'b0;

    while (sb.nibbles_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("covered %0d requests (char %0d, cursor %0d, integer %0d, init %0d)",
             sb.requests_seen, sb.per_kind[K_CHAR], sb.per_kind[K_CURSOR],
             sb.per_kind[K_INT], sb.per_kind[K_INIT]);
    $display("checked %0d nibble beats, %0d mismatches", sb.beats_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.nibbles_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/lcdw_pkg.sv
rtl/core/lcdw_fifo.sv
rtl/core/lcdw_front.sv
rtl/core/lcdw_back.sv
rtl/core/lcd_4bit_write_sequencer.sv
verif/lcdw_nibble_scoreboard.sv
verif/tb_lcd_4bit_write_sequencer.sv
